>>> hdl/ascon_aead_engine_core_defines.svh
//------------------------------------------------------------------------------
// ascon_aead_engine_core_defines.svh
// Assertion macros used by the engine core RTL.
//------------------------------------------------------------------------------
`ifndef ASCON_AEAD_ENGINE_CORE_DEFINES_SVH
`define ASCON_AEAD_ENGINE_CORE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define ASC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ascon_pkg.sv
//------------------------------------------------------------------------------
// ascon_pkg
// Types, constants and the round-constant table of the AEAD engine.
//------------------------------------------------------------------------------
package ascon_pkg;

  localparam int unsigned INIT_ROUNDS = 12;
  localparam int unsigned DATA_ROUNDS = 6;

  localparam int unsigned IN_DW   = 256;
  localparam int unsigned OUT_DW  = 256;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_DW  = 64;
  localparam int unsigned CFG_AW  = 5;

  typedef logic [63:0]      word_t;
  typedef logic [4:0][63:0] state_t;

  localparam word_t ENGINE_IV = 64'h80400c0600000000;

  // Round-constant index of the first round of each permutation.
  localparam logic [3:0] INIT_START = 4'(16 - INIT_ROUNDS);
  localparam logic [3:0] DATA_START = 4'(16 - DATA_ROUNDS);
  localparam logic [3:0] RND_LAST   = 4'hF;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_AD    = 2'd1,
    CMD_MSG   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_KEY_HI = 2'd1,
    REG_KEY_LO = 2'd2
  } reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_AD,
    JOB_MSG
  } job_e;

  typedef struct packed {
    logic  decrypt;
    word_t key_hi;
    word_t key_lo;
  } cfg_t;

  function automatic word_t ror64(input word_t v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  function automatic logic [7:0] round_const(input logic [3:0] idx);
    logic [7:0] rc;
    unique case (idx)
      4'h0:    rc = 8'h3C;
      4'h1:    rc = 8'h2D;
      4'h2:    rc = 8'h1E;
      4'h3:    rc = 8'h0F;
      4'h4:    rc = 8'hF0;
      4'h5:    rc = 8'hE1;
      4'h6:    rc = 8'hD2;
      4'h7:    rc = 8'hC3;
      4'h8:    rc = 8'hB4;
      4'h9:    rc = 8'hA5;
      4'hA:    rc = 8'h96;
      4'hB:    rc = 8'h87;
      4'hC:    rc = 8'h78;
      4'hD:    rc = 8'h69;
      4'hE:    rc = 8'h5A;
      4'hF:    rc = 8'h4B;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

endpackage

>>> hdl/ascon_aead_engine_core.sv
//------------------------------------------------------------------------------
// ascon_aead_engine_core
// Ascon-style AEAD engine, 320-bit state, 128-bit rate, one round per cycle.
//
//  port group   direction  carries
//  in_*         stream in  command, block, last flag, expected tag
//  out_*        stream out data block, tag, tag-match flag, final flag
//  cfg_*        APB slave  decrypt mode, key high, key low
//
// A start or a final message block runs 12 rounds, an AD or plain
// message block 6 rounds, all on the single round unit.
// Ignored commands complete in the accept cycle.
// Reset clears the state words, the control logic, the output valid flag and the mode and key registers.
// A finished message block waits in its last round while the output
// register still holds an untaken result.
//------------------------------------------------------------------------------
`include "ascon_aead_engine_core_defines.svh"

module ascon_aead_engine_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // block_high, block_low, expected_tag_high, expected_tag_low
  input  logic [ascon_pkg::IN_DW-1:0]    in_tdata,
  // cmd
  input  logic [ascon_pkg::CMD_W-1:0]    in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // data_high, data_low, tag_high, tag_low
  output logic [ascon_pkg::OUT_DW-1:0]   out_tdata,
  // tag_ok
  output logic [0:0]                     out_tuser,
  output logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ascon_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [ascon_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [ascon_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import ascon_pkg::*;

  cfg_t   cfg;
  state_e st_r, st_nxt;
  state_t x_r, x_nxt, rnd_out;
  logic [3:0] rnd_r, rnd_nxt;
  job_e   job_r, job_nxt;
  logic   ad_closed_r, ad_closed_nxt;

  // Per-job payload captured at accept.
  word_t  jdh_r, jdh_nxt, jdl_r, jdl_nxt;
  word_t  jexp_hi_r, jexp_hi_nxt, jexp_lo_r, jexp_lo_nxt;
  logic   jlast_r, jlast_nxt, jdec_r, jdec_nxt;

  // Output register.
  logic   out_vld_r, out_vld_nxt;
  word_t  o_dh_r, o_dh_nxt, o_dl_r, o_dl_nxt, o_th_r, o_th_nxt, o_tl_r, o_tl_nxt;
  logic   o_ok_r, o_ok_nxt, o_last_r, o_last_nxt;

  logic   in_acc;
  word_t  bh, bl, th, tl;
  logic   out_busy;

  ascon_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_o   (cfg)
  );

  ascon_round u_round (
    .st_i (x_r),
    .rc_i (round_const(rnd_r)),
    .st_o (rnd_out)
  );

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign bh        = in_tdata[63:0];
  assign bl        = in_tdata[127:64];
  assign out_busy  = out_vld_r & ~out_tready;
  assign th        = rnd_out[3] ^ cfg.key_hi;
  assign tl        = rnd_out[4] ^ cfg.key_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      x_r         <= '0;
      rnd_r       <= '0;
      job_r       <= JOB_START;
      ad_closed_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      x_r         <= x_nxt;
      rnd_r       <= rnd_nxt;
      job_r       <= job_nxt;
      ad_closed_r <= ad_closed_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jdh_r     <= jdh_nxt;
    jdl_r     <= jdl_nxt;
    jexp_hi_r <= jexp_hi_nxt;
    jexp_lo_r <= jexp_lo_nxt;
    jlast_r   <= jlast_nxt;
    jdec_r    <= jdec_nxt;
    o_dh_r    <= o_dh_nxt;
    o_dl_r    <= o_dl_nxt;
    o_th_r    <= o_th_nxt;
    o_tl_r    <= o_tl_nxt;
    o_ok_r    <= o_ok_nxt;
    o_last_r  <= o_last_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    x_nxt         = x_r;
    rnd_nxt       = rnd_r;
    job_nxt       = job_r;
    ad_closed_nxt = ad_closed_r;
    jdh_nxt       = jdh_r;
    jdl_nxt       = jdl_r;
    jexp_hi_nxt   = jexp_hi_r;
    jexp_lo_nxt   = jexp_lo_r;
    jlast_nxt     = jlast_r;
    jdec_nxt      = jdec_r;
    out_vld_nxt   = out_vld_r & ~out_tready;
    o_dh_nxt      = o_dh_r;
    o_dl_nxt      = o_dl_r;
    o_th_nxt      = o_th_r;
    o_tl_nxt      = o_tl_r;
    o_ok_nxt      = o_ok_r;
    o_last_nxt    = o_last_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            CMD_START: begin
              x_nxt[0]      = ENGINE_IV;
              x_nxt[1]      = cfg.key_hi;
              x_nxt[2]      = cfg.key_lo;
              x_nxt[3]      = bh;
              x_nxt[4]      = bl;
              ad_closed_nxt = 1'b0;
              rnd_nxt       = INIT_START;
              job_nxt       = JOB_START;
              st_nxt        = ST_RUN;
            end
            CMD_AD: begin
              // Associated data after the first message block is dropped.
              if (!ad_closed_r) begin
                x_nxt[0] = x_r[0] ^ bh;
                x_nxt[1] = x_r[1] ^ bl;
                rnd_nxt  = DATA_START;
                job_nxt  = JOB_AD;
                st_nxt   = ST_RUN;
              end
            end
            CMD_MSG: begin
              // Domain separation happens once, on the first message block.
              x_nxt[4]      = x_r[4] ^ {63'd0, ~ad_closed_r};
              ad_closed_nxt = 1'b1;
              jdh_nxt       = x_r[0] ^ bh;
              jdl_nxt       = x_r[1] ^ bl;
              x_nxt[0]      = cfg.decrypt ? bh : (x_r[0] ^ bh);
              x_nxt[1]      = cfg.decrypt ? bl : (x_r[1] ^ bl);
              jexp_hi_nxt   = in_tdata[191:128];
              jexp_lo_nxt   = in_tdata[255:192];
              jlast_nxt     = in_tlast;
              jdec_nxt      = cfg.decrypt;
              if (in_tlast) begin
                x_nxt[2] = x_r[2] ^ cfg.key_hi;
                x_nxt[3] = x_r[3] ^ cfg.key_lo;
                rnd_nxt  = INIT_START;
              end else begin
                rnd_nxt  = DATA_START;
              end
              job_nxt = JOB_MSG;
              st_nxt  = ST_RUN;
            end
            default: ;
          endcase
        end
      end

      ST_RUN: begin
        if (rnd_r != RND_LAST) begin
          x_nxt   = rnd_out;
          rnd_nxt = rnd_r + 4'd1;
        end else if (!(job_r == JOB_MSG && out_busy)) begin
          x_nxt  = rnd_out;
          st_nxt = ST_IDLE;
          if (job_r == JOB_START) begin
            x_nxt[3] = th;
            x_nxt[4] = tl;
          end
          if (job_r == JOB_MSG) begin
            out_vld_nxt = 1'b1;
            o_dh_nxt    = jdh_r;
            o_dl_nxt    = jdl_r;
            o_th_nxt    = jlast_r ? th : '0;
            o_tl_nxt    = jlast_r ? tl : '0;
            o_ok_nxt    = jdec_r & jlast_r & (th == jexp_hi_r) & (tl == jexp_lo_r);
            o_last_nxt  = jlast_r;
          end
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {o_tl_r, o_th_r, o_dl_r, o_dh_r};
  assign out_tuser  = o_ok_r;
  assign out_tlast  = o_last_r;

  `ASC_ASSERT(a_start_loads_init, (in_acc && in_tuser == CMD_START) |=> (st_r == ST_RUN && rnd_r == INIT_START), "start transaction did not begin the initial permutation")
  `ASC_ASSERT(a_tag_zero_mid, (out_vld_r && !o_last_r) |-> (o_th_r == '0 && o_tl_r == '0), "nonzero tag on a non-final result")
  `ASC_ASSERT(a_ok_only_final, (out_vld_r && o_ok_r) |-> o_last_r, "tag match flagged on a non-final result")
  `ASC_ASSERT(a_result_after_run, $rose(out_vld_r) |-> $past(st_r == ST_RUN && job_r == JOB_MSG), "result appeared without a finished message job")

endmodule

>>> hdl/ascon_round.sv
//------------------------------------------------------------------------------
// ascon_round
// One permutation round: constant addition, 5-bit S-box layer, linear layer.
//------------------------------------------------------------------------------
module ascon_round (
  input  ascon_pkg::state_t   st_i,
  input  logic [7:0]          rc_i,
  output ascon_pkg::state_t   st_o
);
  import ascon_pkg::*;

  word_t a0, b0, c0, d0, e0;
  word_t a1, b1, c1, d1, e1;
  word_t t0, t1, t2, t3, t4;
  word_t a2, b2, c2, d2, e2;

  always_comb begin
    a0 = st_i[0] ^ st_i[4];
    e0 = st_i[4] ^ st_i[3];
    c0 = st_i[2] ^ {56'd0, rc_i} ^ st_i[1];
    b0 = st_i[1];
    d0 = st_i[3];

    t0 = ~a0 & b0;
    t1 = ~b0 & c0;
    t2 = ~c0 & d0;
    t3 = ~d0 & e0;
    t4 = ~e0 & a0;

    a1 = a0 ^ t1;
    b1 = b0 ^ t2;
    c1 = c0 ^ t3;
    d1 = d0 ^ t4;
    e1 = e0 ^ t0;

    b2 = b1 ^ a1;
    a2 = a1 ^ e1;
    d2 = d1 ^ c1;
    c2 = ~c1;
    e2 = e1;

    st_o[0] = a2 ^ ror64(a2, 19) ^ ror64(a2, 28);
    st_o[1] = b2 ^ ror64(b2, 61) ^ ror64(b2, 39);
    st_o[2] = c2 ^ ror64(c2, 1)  ^ ror64(c2, 6);
    st_o[3] = d2 ^ ror64(d2, 10) ^ ror64(d2, 17);
    st_o[4] = e2 ^ ror64(e2, 7)  ^ ror64(e2, 41);
  end

endmodule

>>> hdl/ascon_regs.sv
//------------------------------------------------------------------------------
// ascon_regs
// APB register file: mode bit and the two key halves.
//------------------------------------------------------------------------------
module ascon_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ascon_pkg::CFG_AW-1:0]  paddr,
  input  logic [ascon_pkg::CFG_DW-1:0]  pwdata,
  output logic [ascon_pkg::CFG_DW-1:0]  prdata,
  output logic                          pready,
  output ascon_pkg::cfg_t               cfg_o
);
  import ascon_pkg::*;

  logic       dec_r;
  word_t      key_hi_r;
  word_t      key_lo_r;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  // Registers sit on 8-byte boundaries.
  assign reg_sel = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r    <= 1'b0;
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MODE:   dec_r    <= pwdata[0];
        REG_KEY_HI: key_hi_r <= pwdata;
        REG_KEY_LO: key_lo_r <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODE:   prdata = {63'd0, dec_r};
      REG_KEY_HI: prdata = key_hi_r;
      REG_KEY_LO: prdata = key_lo_r;
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = '{decrypt: dec_r, key_hi: key_hi_r, key_lo: key_lo_r};

endmodule
